// ===== rtl/lmpp_pkg.sv =====
// Shared constants, types and datapath step functions for the L-marker pose block.
package lmpp_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int CORDIC_STAGES = 16;
   localparam int TOL_W         = 23;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(3277);

   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int ROOT_W   = DIFF_W + 1;
   localparam int SQ_W     = 2 * ROOT_W;
   localparam int REM_W    = SQ_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int POS_W    = $clog2(DIFF_W);
   localparam int NORM_EXP = 40;
   localparam int SHIFT_W  = 6;
   localparam int ANG_W    = NORM_EXP + 5;
   localparam int ROT_W    = 34;
   localparam int ZR_W     = 33;
   localparam int ANG_OUT_W = 16;

   localparam logic signed [ROT_W-1:0] GAIN_Q30     = ROT_W'(652032874);
   localparam logic [31:0]             QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0]             ROUND_HALF   = 32'h0000_8000;

   localparam int APB_AW = 3;
   localparam int APB_DW = 32;
   localparam logic [APB_AW-1:0] ADDR_TOL = '0;

   localparam int DEPTH = 13 + 2 * ROOT_W + 2 * CORDIC_STAGES;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_LEG  = 2'd1,
      STAT_PYTH = 2'd2
   } status_type;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] x;
      logic [2:0][COORD_WIDTH-1:0] y;
   } pts_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        h;
      logic                     leg_fail;
      coord_type                ox;
      coord_type                oy;
      logic signed [DIFF_W-1:0] vx;
      logic signed [DIFF_W-1:0] vy;
   } mid_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic [31:0]             z;
   } vec_type;

   typedef struct packed {
      status_type status;
      coord_type  ox;
      coord_type  oy;
      logic       zero;
   } tail_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ZR_W-1:0]  z;
   } rot_type;

   typedef struct packed {
      status_type            status;
      coord_type             ox;
      coord_type             oy;
      logic [ANG_OUT_W-1:0]  yaw;
   } hold_type;

   // arctan(2^-i), 2^32 units per turn
   function automatic logic [31:0] atan_val(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

   // one bit of a restoring square root
   function automatic sqrt_type sqrt_step(input sqrt_type s, input int b);
      sqrt_type r;
      logic [REM_W-1:0] trial;
      r = s;
      trial = (REM_W'(s.root) << (b + 1)) + (REM_W'(1) << (2 * b));
      if (trial <= s.rem) begin
         r.rem  = s.rem - trial;
         r.root = s.root | (ROOT_W'(1) << b);
      end
      return r;
   endfunction

   // vectoring micro-rotation
   function automatic vec_type vec_step(input vec_type v, input int i);
      vec_type r;
      logic signed [ANG_W-1:0] xs;
      logic signed [ANG_W-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      r = v;
      if (!v.y[ANG_W-1]) begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + atan_val(i);
      end else begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - atan_val(i);
      end
      return r;
   endfunction

   // rotation micro-rotation
   function automatic rot_type rot_step(input rot_type v, input int i);
      rot_type r;
      logic signed [ROT_W-1:0] xs;
      logic signed [ROT_W-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      r = v;
      if (!v.z[ZR_W-1]) begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - $signed(ZR_W'(atan_val(i)));
      end else begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + $signed(ZR_W'(atan_val(i)));
      end
      return r;
   endfunction

   // Q30 to Q1.14, rounded and clamped
   function automatic logic [ANG_OUT_W-1:0] q14(input logic signed [ROT_W-1:0] v);
      logic signed [ROT_W-1:0] t;
      t = v + $signed(ROT_W'(32768));
      t = t >>> 16;
      if (t > 16384) t = 16384;
      if (t < -16384) t = -16384;
      return t[ANG_OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/lmpp_if.sv =====
// Valid/ready channel interfaces for marker triples and pose results.
interface lmpp_req_if import lmpp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_a_x;
   coord_type point_a_y;
   coord_type point_b_x;
   coord_type point_b_y;
   coord_type point_c_x;
   coord_type point_c_y;

   modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                   point_c_x, point_c_y, input ready);
   modport sink   (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                   point_c_x, point_c_y, output ready);
endinterface

interface lmpp_rsp_if import lmpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   coord_type            origin_x;
   coord_type            origin_y;
   logic [ANG_OUT_W-1:0] yaw_angle;
   logic [ANG_OUT_W-1:0] quat_z;
   logic [ANG_OUT_W-1:0] quat_w;

   modport source (output valid, status, origin_x, origin_y, yaw_angle, quat_z, quat_w,
                   input ready);
   modport sink   (input valid, status, origin_x, origin_y, yaw_angle, quat_z, quat_w,
                   output ready);
endinterface

// ===== rtl/l_marker_planar_pose.sv =====
// Top level: pipelined planar pose of an L-shaped three-marker pattern.
//
//   channel   dir  beat
//   req_bus   in   three marker positions, x/y signed Q.16
//   rsp_bus   out  status, origin, yaw, quaternion z/w
//   csr       in   APB, length_tolerance at byte address 0
//
// One beat per cycle while results are taken; the pipeline depth DEPTH is
// set by the two 26-step square roots and the two CORDIC chains.
// Synchronous reset clears valid bits and loads the tolerance register with 3277.
// A held result stalls the whole pipeline in place; nothing is dropped.
module l_marker_planar_pose import lmpp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lmpp_req_if.sink          req_bus,
   lmpp_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   logic [TOL_W-1:0] tol_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             adv;

   pts_type                    s0_pts_ff, s1_pts_ff, s2_pts_ff;
   logic [2:0][DIFF_W-1:0]     s1_mx_ff, s1_my_ff;
   logic [2:0][DIFF_W-1:0]     s1_mx_in, s1_my_in;
   logic [2:0][SQ_W-1:0]       s2_sqx_ff, s2_sqy_ff;

   sqrt_type sq1_ff     [0:ROOT_W][0:2];
   pts_type  sq1_pts_ff [0:ROOT_W];

   logic [ROOT_W-1:0] s4_h_ff, s4_l1_ff, s4_l2_ff, s4_h_in, s4_l1_in, s4_l2_in;
   logic [1:0]        s4_hi_ff, s4_hi_in;
   pts_type           s4_pts_ff;

   logic [ROOT_W-1:0]        s5_h_ff, s5_l1_ff, s5_l2_ff;
   logic                     s5_leg_ff, s5_leg_in;
   coord_type                s5_ox_ff, s5_oy_ff, s5_ox_in, s5_oy_in;
   logic signed [DIFF_W-1:0] s5_v1x_ff, s5_v1y_ff, s5_v2x_ff, s5_v2y_ff;
   logic signed [DIFF_W-1:0] s5_v1x_in, s5_v1y_in, s5_v2x_in, s5_v2y_in;

   logic [ROOT_W-1:0]        s6_h_ff;
   logic                     s6_leg_ff;
   coord_type                s6_ox_ff, s6_oy_ff;
   logic signed [DIFF_W-1:0] s6_v1x_ff, s6_v1y_ff, s6_v2x_ff, s6_v2y_ff;
   logic [SQ_W-1:0]          s6_l1sq_ff, s6_l2sq_ff;
   logic signed [PROD_W-1:0] s6_c1_ff, s6_c2_ff, s6_d1_ff, s6_d2_ff;

   mid_type  s7_mid_in;
   sqrt_type sq2_ff     [0:ROOT_W];
   mid_type  sq2_mid_ff [0:ROOT_W];

   status_type               s8_status_ff, s8_status_in;
   coord_type                s8_ox_ff, s8_oy_ff;
   logic signed [DIFF_W-1:0] s8_vx_ff, s8_vy_ff;
   logic [SHIFT_W-1:0]       s8_shift_ff, s8_shift_in;
   logic                     s8_zero_ff, s8_zero_in;

   logic signed [ANG_W-1:0] s9_x_ff, s9_y_ff;
   tail_type                s9_tail_ff;

   vec_type  s10_vec_in;
   vec_type  vec_ff  [0:CORDIC_STAGES];
   tail_type tail_ff [0:CORDIC_STAGES];

   logic [ANG_OUT_W-1:0] s11_yaw_in;
   rot_type  rot_ff  [0:CORDIC_STAGES];
   hold_type hold_ff [0:CORDIC_STAGES];

   status_type           out_status_ff;
   coord_type            out_ox_ff, out_oy_ff;
   logic [ANG_OUT_W-1:0] out_yaw_ff, out_qz_ff, out_qw_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (psel && penable && pwrite && paddr == ADDR_TOL) begin
         tol_ff <= pwdata[TOL_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_TOL) ? APB_DW'(tol_ff) : '0;

   // flow control
   assign adv           = !valid_ff[DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_bus.valid};
      end
   end

   // pairwise deltas
   always_comb begin
      logic signed [DIFF_W-1:0] dx, dy;
      for (int k = 0; k < 3; k++) begin
         dx = DIFF_W'($signed(s0_pts_ff.x[k])) - DIFF_W'($signed(s0_pts_ff.x[(k + 1) % 3]));
         dy = DIFF_W'($signed(s0_pts_ff.y[k])) - DIFF_W'($signed(s0_pts_ff.y[(k + 1) % 3]));
         s1_mx_in[k] = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
         s1_my_in[k] = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      end
   end

   // hypotenuse pick
   always_comb begin
      logic [ROOT_W-1:0] d0, d1, d2;
      d0 = sq1_ff[ROOT_W][0].root;
      d1 = sq1_ff[ROOT_W][1].root;
      d2 = sq1_ff[ROOT_W][2].root;
      s4_hi_in = 2'd0;
      s4_h_in  = d0;
      if (d1 > d0) begin
         s4_hi_in = 2'd1;
         s4_h_in  = d1;
      end
      if (d2 > s4_h_in) begin
         s4_hi_in = 2'd2;
         s4_h_in  = d2;
      end
      unique case (s4_hi_in)
         2'd1: begin
            s4_l1_in = d2;
            s4_l2_in = d0;
         end
         2'd2: begin
            s4_l1_in = d0;
            s4_l2_in = d1;
         end
         default: begin
            s4_l1_in = d1;
            s4_l2_in = d2;
         end
      endcase
   end

   // leg check, origin, leg vectors
   always_comb begin
      logic [1:0]        o, a, b;
      logic [ROOT_W-1:0] ld;
      unique case (s4_hi_ff)
         2'd1: begin
            o = 2'd0; a = 2'd1; b = 2'd2;
         end
         2'd2: begin
            o = 2'd1; a = 2'd2; b = 2'd0;
         end
         default: begin
            o = 2'd2; a = 2'd0; b = 2'd1;
         end
      endcase
      ld = (s4_l1_ff > s4_l2_ff) ? s4_l1_ff - s4_l2_ff : s4_l2_ff - s4_l1_ff;
      s5_leg_in = ld > ROOT_W'(tol_ff);
      s5_ox_in  = s4_pts_ff.x[o];
      s5_oy_in  = s4_pts_ff.y[o];
      s5_v1x_in = DIFF_W'($signed(s4_pts_ff.x[a])) - DIFF_W'($signed(s4_pts_ff.x[o]));
      s5_v1y_in = DIFF_W'($signed(s4_pts_ff.y[a])) - DIFF_W'($signed(s4_pts_ff.y[o]));
      s5_v2x_in = DIFF_W'($signed(s4_pts_ff.x[b])) - DIFF_W'($signed(s4_pts_ff.x[o]));
      s5_v2y_in = DIFF_W'($signed(s4_pts_ff.y[b])) - DIFF_W'($signed(s4_pts_ff.y[o]));
   end

   // cross/dot signs pick the yaw leg
   always_comb begin
      logic signed [PROD_W:0] cr, dt;
      logic                   pick;
      cr = (PROD_W + 1)'(s6_c1_ff) - (PROD_W + 1)'(s6_c2_ff);
      dt = (PROD_W + 1)'(s6_d1_ff) + (PROD_W + 1)'(s6_d2_ff);
      pick = (!cr[PROD_W] && cr != '0) || (cr == '0 && dt[PROD_W]);
      s7_mid_in.h        = s6_h_ff;
      s7_mid_in.leg_fail = s6_leg_ff;
      s7_mid_in.ox       = s6_ox_ff;
      s7_mid_in.oy       = s6_oy_ff;
      s7_mid_in.vx       = pick ? s6_v2x_ff : s6_v1x_ff;
      s7_mid_in.vy       = pick ? s6_v2y_ff : s6_v1y_ff;
   end

   // Pythagoras check, normalize shift
   always_comb begin
      mid_type           m;
      logic [ROOT_W-1:0] p, hd;
      logic [DIFF_W-1:0] ax, ay, om;
      logic [POS_W-1:0]  pos;
      m  = sq2_mid_ff[ROOT_W];
      p  = sq2_ff[ROOT_W].root;
      hd = (m.h > p) ? m.h - p : p - m.h;
      if (m.leg_fail)                s8_status_in = STAT_LEG;
      else if (hd > ROOT_W'(tol_ff)) s8_status_in = STAT_PYTH;
      else                           s8_status_in = STAT_OK;
      ax  = m.vx[DIFF_W-1] ? DIFF_W'(-m.vx) : DIFF_W'(m.vx);
      ay  = m.vy[DIFF_W-1] ? DIFF_W'(-m.vy) : DIFF_W'(m.vy);
      om  = ax | ay;
      pos = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (om[i]) pos = POS_W'(i);
      end
      s8_shift_in = SHIFT_W'(NORM_EXP) - SHIFT_W'(pos);
      s8_zero_in  = (om == '0);
   end

   // quadrant fold ahead of vectoring
   always_comb begin
      s10_vec_in.x = s9_x_ff;
      s10_vec_in.y = s9_y_ff;
      s10_vec_in.z = '0;
      if (s9_x_ff[ANG_W-1]) begin
         if (!s9_y_ff[ANG_W-1]) begin
            s10_vec_in.x = s9_y_ff;
            s10_vec_in.y = -s9_x_ff;
            s10_vec_in.z = QUARTER_TURN;
         end else begin
            s10_vec_in.x = -s9_y_ff;
            s10_vec_in.y = s9_x_ff;
            s10_vec_in.z = -QUARTER_TURN;
         end
      end
   end

   always_comb begin
      logic [31:0] zr;
      zr = vec_ff[CORDIC_STAGES].z + ROUND_HALF;
      s11_yaw_in = tail_ff[CORDIC_STAGES].zero ? '0 : zr[31:16];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_pts_ff.x <= {req_bus.point_c_x, req_bus.point_b_x, req_bus.point_a_x};
         s0_pts_ff.y <= {req_bus.point_c_y, req_bus.point_b_y, req_bus.point_a_y};

         s1_pts_ff <= s0_pts_ff;
         s1_mx_ff  <= s1_mx_in;
         s1_my_ff  <= s1_my_in;

         s2_pts_ff <= s1_pts_ff;
         for (int k = 0; k < 3; k++) begin
            s2_sqx_ff[k] <= SQ_W'(PROD_W'(s1_mx_ff[k]) * PROD_W'(s1_mx_ff[k]));
            s2_sqy_ff[k] <= SQ_W'(PROD_W'(s1_my_ff[k]) * PROD_W'(s1_my_ff[k]));
         end

         sq1_pts_ff[0] <= s2_pts_ff;
         for (int k = 0; k < 3; k++) begin
            sq1_ff[0][k].rem  <= REM_W'(s2_sqx_ff[k]) + REM_W'(s2_sqy_ff[k]);
            sq1_ff[0][k].root <= '0;
         end
         for (int j = 0; j < ROOT_W; j++) begin
            sq1_pts_ff[j+1] <= sq1_pts_ff[j];
            for (int k = 0; k < 3; k++) begin
               sq1_ff[j+1][k] <= sqrt_step(sq1_ff[j][k], ROOT_W - 1 - j);
            end
         end

         s4_pts_ff <= sq1_pts_ff[ROOT_W];
         s4_hi_ff  <= s4_hi_in;
         s4_h_ff   <= s4_h_in;
         s4_l1_ff  <= s4_l1_in;
         s4_l2_ff  <= s4_l2_in;

         s5_h_ff   <= s4_h_ff;
         s5_l1_ff  <= s4_l1_ff;
         s5_l2_ff  <= s4_l2_ff;
         s5_leg_ff <= s5_leg_in;
         s5_ox_ff  <= s5_ox_in;
         s5_oy_ff  <= s5_oy_in;
         s5_v1x_ff <= s5_v1x_in;
         s5_v1y_ff <= s5_v1y_in;
         s5_v2x_ff <= s5_v2x_in;
         s5_v2y_ff <= s5_v2y_in;

         s6_h_ff    <= s5_h_ff;
         s6_leg_ff  <= s5_leg_ff;
         s6_ox_ff   <= s5_ox_ff;
         s6_oy_ff   <= s5_oy_ff;
         s6_v1x_ff  <= s5_v1x_ff;
         s6_v1y_ff  <= s5_v1y_ff;
         s6_v2x_ff  <= s5_v2x_ff;
         s6_v2y_ff  <= s5_v2y_ff;
         s6_l1sq_ff <= SQ_W'(s5_l1_ff) * SQ_W'(s5_l1_ff);
         s6_l2sq_ff <= SQ_W'(s5_l2_ff) * SQ_W'(s5_l2_ff);
         s6_c1_ff   <= PROD_W'(s5_v2x_ff) * PROD_W'(s5_v1y_ff);
         s6_c2_ff   <= PROD_W'(s5_v2y_ff) * PROD_W'(s5_v1x_ff);
         s6_d1_ff   <= PROD_W'(s5_v1x_ff) * PROD_W'(s5_v2x_ff);
         s6_d2_ff   <= PROD_W'(s5_v1y_ff) * PROD_W'(s5_v2y_ff);

         sq2_mid_ff[0]  <= s7_mid_in;
         sq2_ff[0].rem  <= REM_W'(s6_l1sq_ff) + REM_W'(s6_l2sq_ff);
         sq2_ff[0].root <= '0;
         for (int j = 0; j < ROOT_W; j++) begin
            sq2_mid_ff[j+1] <= sq2_mid_ff[j];
            sq2_ff[j+1]     <= sqrt_step(sq2_ff[j], ROOT_W - 1 - j);
         end

         s8_status_ff <= s8_status_in;
         s8_ox_ff     <= sq2_mid_ff[ROOT_W].ox;
         s8_oy_ff     <= sq2_mid_ff[ROOT_W].oy;
         s8_vx_ff     <= sq2_mid_ff[ROOT_W].vx;
         s8_vy_ff     <= sq2_mid_ff[ROOT_W].vy;
         s8_shift_ff  <= s8_shift_in;
         s8_zero_ff   <= s8_zero_in;

         s9_x_ff           <= ANG_W'(s8_vx_ff) <<< s8_shift_ff;
         s9_y_ff           <= ANG_W'(s8_vy_ff) <<< s8_shift_ff;
         s9_tail_ff.status <= s8_status_ff;
         s9_tail_ff.ox     <= s8_ox_ff;
         s9_tail_ff.oy     <= s8_oy_ff;
         s9_tail_ff.zero   <= s8_zero_ff;

         vec_ff[0]  <= s10_vec_in;
         tail_ff[0] <= s9_tail_ff;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            vec_ff[i+1]  <= vec_step(vec_ff[i], i);
            tail_ff[i+1] <= tail_ff[i];
         end

         rot_ff[0].x        <= GAIN_Q30;
         rot_ff[0].y        <= '0;
         rot_ff[0].z        <= ZR_W'($signed(s11_yaw_in)) <<< 15;
         hold_ff[0].status  <= tail_ff[CORDIC_STAGES].status;
         hold_ff[0].ox      <= tail_ff[CORDIC_STAGES].ox;
         hold_ff[0].oy      <= tail_ff[CORDIC_STAGES].oy;
         hold_ff[0].yaw     <= s11_yaw_in;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            rot_ff[i+1]  <= rot_step(rot_ff[i], i);
            hold_ff[i+1] <= hold_ff[i];
         end

         out_status_ff <= hold_ff[CORDIC_STAGES].status;
         if (hold_ff[CORDIC_STAGES].status == STAT_OK) begin
            out_ox_ff  <= hold_ff[CORDIC_STAGES].ox;
            out_oy_ff  <= hold_ff[CORDIC_STAGES].oy;
            out_yaw_ff <= hold_ff[CORDIC_STAGES].yaw;
            out_qz_ff  <= q14(rot_ff[CORDIC_STAGES].y);
            out_qw_ff  <= q14(rot_ff[CORDIC_STAGES].x);
         end else begin
            out_ox_ff  <= '0;
            out_oy_ff  <= '0;
            out_yaw_ff <= '0;
            out_qz_ff  <= '0;
            out_qw_ff  <= '0;
         end
      end
   end

   assign rsp_bus.valid     = valid_ff[DEPTH-1];
   assign rsp_bus.status    = out_status_ff;
   assign rsp_bus.origin_x  = out_ox_ff;
   assign rsp_bus.origin_y  = out_oy_ff;
   assign rsp_bus.yaw_angle = out_yaw_ff;
   assign rsp_bus.quat_z    = out_qz_ff;
   assign rsp_bus.quat_w    = out_qw_ff;

endmodule

// ===== rtl/lmpp_checker.sv =====
// Port-level checks on the pose result channel, bound to the top level.
module lmpp_checker import lmpp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input coord_type            rsp_origin_x,
   input coord_type            rsp_origin_y,
   input logic [ANG_OUT_W-1:0] rsp_yaw_angle,
   input logic [ANG_OUT_W-1:0] rsp_quat_z,
   input logic [ANG_OUT_W-1:0] rsp_quat_w
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_yaw_angle))
      else $error("result beat changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_origin_x == '0 && rsp_origin_y == '0 && rsp_yaw_angle == '0 &&
         rsp_quat_z == '0 && rsp_quat_w == '0)
      else $error("rejected pattern carries nonzero fields");

   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3 &&
         $signed(rsp_quat_z) <= 16384 && $signed(rsp_quat_z) >= -16384 &&
         $signed(rsp_quat_w) <= 16384 && $signed(rsp_quat_w) >= -16384)
      else $error("status code or quaternion out of range");

endmodule

bind l_marker_planar_pose lmpp_checker u_lmpp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_origin_x  (rsp_bus.origin_x),
   .rsp_origin_y  (rsp_bus.origin_y),
   .rsp_yaw_angle (rsp_bus.yaw_angle),
   .rsp_quat_z    (rsp_bus.quat_z),
   .rsp_quat_w    (rsp_bus.quat_w)
);

// ===== dv/tb_lmpp_if.sv =====
`timescale 1ns / 1ps
// Beat record types for the pose testbench.
package tb_lmpp_types;
   import lmpp_pkg::*;

   typedef struct {
      coord_type ax, ay, bx, by, cx, cy;
   } triple_type;

   typedef struct {
      status_type             status;
      coord_type              ox;
      coord_type              oy;
      logic [ANG_OUT_W-1:0]   yaw;
      logic [ANG_OUT_W-1:0]   qz;
      logic [ANG_OUT_W-1:0]   qw;
   } pose_type;
endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the L-marker planar pose block.
module tb_top import lmpp_pkg::*, tb_lmpp_types::*;;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [APB_AW-1:0] paddr = '0;
   logic [APB_DW-1:0] pwdata = '0;
   logic [APB_DW-1:0] prdata;
   logic pready;

   lmpp_req_if req_bus ();
   lmpp_rsp_if rsp_bus ();

   l_marker_planar_pose dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   triple_type pending_q[$];
   pose_type   pose_q[$];
   logic [TOL_W-1:0] tol = TOL_RESET;
   int  errors = 0;
   int  quiet = 0;
   bit  calm = 0;
   bit  hold_off = 0;
   bit  in_fire = 0;

   function automatic longint wrap16(longint v);
      longint u;
      u = v & 64'hFFFF;
      return (u >= 32768) ? u - 65536 : u;
   endfunction

   // floor sqrt of a nonnegative value below 2^90
   function automatic longint isqrt(logic [89:0] n);
      logic [89:0] r, t;
      r = 0;
      for (int b = 44; b >= 0; b--) begin
         t = r | (90'd1 << b);
         if (t * t <= n) r = t;
      end
      return longint'(r);
   endfunction

   function automatic longint seg_len(longint ax, longint ay, longint bx, longint by);
      logic signed [89:0] dx, dy;
      dx = 90'(ax - bx);
      dy = 90'(ay - by);
      return isqrt(dx * dx + dy * dy);
   endfunction

   function automatic longint yaw_of(longint x, longint y);
      longint z, t, xs, ys, lim;
      z = 0;
      lim = 64'sd1 << 40;
      if (x == 0 && y == 0) return 0;
      while (x < lim && x > -lim && y < lim && y > -lim) begin
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = longint'(QUARTER_TURN);
         end else begin
            x = -y; y = t; z = -longint'(QUARTER_TURN);
         end
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_val(i));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_val(i));
         end
      end
      return wrap16((z + 32768) >>> 16);
   endfunction

   function automatic longint to_q14(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic pose_type solve_pose(triple_type t);
      pose_type r;
      longint px[3], py[3], d[3], h, l1, l2, p, v1x, v1y, v2x, v2y, yaw, x, y, z, xs, ys;
      logic signed [127:0] cr, dt;
      int hi, o, a, b;
      px[0] = $signed(t.ax); py[0] = $signed(t.ay);
      px[1] = $signed(t.bx); py[1] = $signed(t.by);
      px[2] = $signed(t.cx); py[2] = $signed(t.cy);
      for (int k = 0; k < 3; k++)
         d[k] = seg_len(px[k], py[k], px[(k + 1) % 3], py[(k + 1) % 3]);
      hi = 0;
      for (int k = 1; k < 3; k++) if (d[k] > d[hi]) hi = k;
      h = d[hi]; l1 = d[(hi + 1) % 3]; l2 = d[(hi + 2) % 3];
      r = '{STAT_OK, '0, '0, '0, '0, '0};
      if ((l1 > l2 ? l1 - l2 : l2 - l1) > longint'(tol)) begin
         r.status = STAT_LEG;
         return r;
      end
      p = isqrt(90'(l1) * 90'(l1) + 90'(l2) * 90'(l2));
      if ((h > p ? h - p : p - h) > longint'(tol)) begin
         r.status = STAT_PYTH;
         return r;
      end
      o = (hi + 2) % 3; a = hi; b = (hi + 1) % 3;
      v1x = px[a] - px[o]; v1y = py[a] - py[o];
      v2x = px[b] - px[o]; v2y = py[b] - py[o];
      cr = 128'(v2x) * 128'(v1y) - 128'(v2y) * 128'(v1x);
      dt = 128'(v1x) * 128'(v2x) + 128'(v1y) * 128'(v2y);
      if (cr > 0 || (cr == 0 && dt < 0)) yaw = yaw_of(v2x, v2y);
      else yaw = yaw_of(v1x, v1y);
      z = yaw * 32768; x = GAIN_Q30; y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_val(i));
         end else begin
            x += ys; y -= xs; z += longint'(atan_val(i));
         end
      end
      r.ox = t.ax; r.oy = t.ay;
      if (o == 1) begin r.ox = t.bx; r.oy = t.by; end
      if (o == 2) begin r.ox = t.cx; r.oy = t.cy; end
      r.yaw = yaw[15:0];
      r.qz = ANG_OUT_W'(to_q14(y));
      r.qw = ANG_OUT_W'(to_q14(x));
      return r;
   endfunction

   function automatic triple_type trip(int ax, int ay, int bx, int by, int cx, int cy);
      triple_type t;
      t.ax = coord_type'(ax); t.ay = coord_type'(ay);
      t.bx = coord_type'(bx); t.by = coord_type'(by);
      t.cx = coord_type'(cx); t.cy = coord_type'(cy);
      return t;
   endfunction

   function automatic coord_type rnd_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(255)) - 128);
         2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: return coord_type'(int'($urandom_range(4095)) - 2048);
      endcase
   endfunction

   // L pattern: origin, leg along (ux,uy), leg along (-uy,ux), shuffled, some jitter
   function automatic triple_type rnd_l();
      triple_type t;
      coord_type o_x, o_y, p_x, p_y, q_x, q_y;
      int ux, uy, s, j;
      s = $urandom_range(3) == 0 ? 2000000 : 200000;
      ux = int'($urandom_range(2 * s)) - s;
      uy = int'($urandom_range(2 * s)) - s;
      j = $urandom_range(3) == 0 ? 20000 : 2000;
      o_x = coord_type'(int'($urandom_range(4000000)) - 2000000);
      o_y = coord_type'(int'($urandom_range(4000000)) - 2000000);
      p_x = o_x + coord_type'(ux + int'($urandom_range(2 * j)) - j);
      p_y = o_y + coord_type'(uy);
      q_x = o_x - coord_type'(uy);
      q_y = o_y + coord_type'(ux + int'($urandom_range(2 * j)) - j);
      case ($urandom_range(2))
         0: t = '{o_x, o_y, p_x, p_y, q_x, q_y};
         1: t = '{p_x, p_y, o_x, o_y, q_x, q_y};
         default: t = '{q_x, q_y, p_x, p_y, o_x, o_y};
      endcase
      return t;
   endfunction

   task automatic csr_write(logic [TOL_W-1:0] v);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= ADDR_TOL; pwdata <= APB_DW'(v);
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      tol = v;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && pose_q.size() == 0);
      repeat (DEPTH + 20) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 0;
      end else if (!req_bus.valid || in_fire) begin
         if (pending_q.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 17)) begin
            req_bus.valid <= 1;
            req_bus.point_a_x <= pending_q[0].ax;
            req_bus.point_a_y <= pending_q[0].ay;
            req_bus.point_b_x <= pending_q[0].bx;
            req_bus.point_b_y <= pending_q[0].by;
            req_bus.point_c_x <= pending_q[0].cx;
            req_bus.point_c_y <= pending_q[0].cy;
         end else begin
            req_bus.valid <= 0;
         end
      end
      rsp_bus.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 17);
   end

   // input acceptance and result checking
   always @(posedge clock) begin
      in_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (req_bus.valid && req_bus.ready) begin
            pose_q.push_back(solve_pose(pending_q.pop_front()));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pose_q.size() == 0) begin
               $error("unexpected beat status=%0d", rsp_bus.status);
               errors++;
            end else begin
               pose_type e;
               e = pose_q.pop_front();
               if (rsp_bus.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_bus.status); errors++;
               end
               if (rsp_bus.origin_x !== e.ox) begin
                  $error("origin_x exp %h got %h", e.ox, rsp_bus.origin_x); errors++;
               end
               if (rsp_bus.origin_y !== e.oy) begin
                  $error("origin_y exp %h got %h", e.oy, rsp_bus.origin_y); errors++;
               end
               if (rsp_bus.yaw_angle !== e.yaw) begin
                  $error("yaw_angle exp %h got %h", e.yaw, rsp_bus.yaw_angle); errors++;
               end
               if (rsp_bus.quat_z !== e.qz) begin
                  $error("quat_z exp %h got %h", e.qz, rsp_bus.quat_z); errors++;
               end
               if (rsp_bus.quat_w !== e.qw) begin
                  $error("quat_w exp %h got %h", e.qw, rsp_bus.quat_w); errors++;
               end
            end
         end
         if (quiet > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic load_directed();
      int mx, mn;
      mx = 32'sh007FFFFF; mn = -32'sh00800000;
      pending_q.push_back(trip(0, 0, 65536, 0, 0, 65536));
      pending_q.push_back(trip(65536, 0, 0, 0, 0, 65536));
      pending_q.push_back(trip(0, 65536, 65536, 0, 0, 0));
      pending_q.push_back(trip(0, 0, -65536, 0, 0, -65536));
      pending_q.push_back(trip(0, 0, -65536, 0, 0, 65536));
      pending_q.push_back(trip(0, 0, 0, 0, 0, 0));
      pending_q.push_back(trip(5, 5, 5, 5, 5, 5));
      pending_q.push_back(trip(0, 0, 0, 0, 65536, 0));
      pending_q.push_back(trip(0, 0, 65536, 0, -65536, 0));
      pending_q.push_back(trip(0, 0, 200000, 0, 0, 100000));
      pending_q.push_back(trip(0, 0, 100000, 0, 100000, 100000));
      pending_q.push_back(trip(mx, mx, mn, mn, mx, mn));
      pending_q.push_back(trip(mn, mn, mx, mn, mn, mx));
      pending_q.push_back(trip(mx, mx, mn, mx, mx, mn));
      pending_q.push_back(trip(mn, 0, mx, 0, 0, mn));
      pending_q.push_back(trip(0, 0, 1, 0, 0, 1));
      pending_q.push_back(trip(-1, -1, -1, -1, -1, -1));
      pending_q.push_back(trip(100, 100, 100, 100 + 65536, 100 - 65536, 100));
   endtask

   initial begin
      triple_type t;
      req_bus.valid = 0;
      {req_bus.point_a_x, req_bus.point_a_y, req_bus.point_b_x} = '0;
      {req_bus.point_b_y, req_bus.point_c_x, req_bus.point_c_y} = '0;
      rsp_bus.ready = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      load_directed();
      drain();
      csr_write('0);
      load_directed();
      drain();
      csr_write(23'h7FFFFF);
      load_directed();
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: csr_write(TOL_RESET);
            1: csr_write(23'(300));
            2: csr_write(23'(6000));
            default: csr_write(23'($urandom));
         endcase
         calm = (phase == 1);
         for (int n = 0; n < 300; n++) begin
            if ($urandom_range(99) < 75) t = rnd_l();
            else t = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                       rnd_coord(), rnd_coord()};
            pending_q.push_back(t);
            if (n == 150 && phase == 2) begin
               wait (pending_q.size() == 0);
               hold_off = 1;
               wait (pose_q.size() == 0);
               hold_off = 0;
            end
         end
         drain();
      end
      calm = 0;
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/lmpp_pkg.sv
rtl/lmpp_if.sv
rtl/l_marker_planar_pose.sv
rtl/lmpp_checker.sv
dv/tb_lmpp_if.sv
dv/tb_top.sv
